// ===== rtl/core/rpg_pkg.sv =====
// Shared constants for the random permutation generator.
`default_nettype none

package rpg_pkg;

    localparam int WORD_W        = 31;
    localparam int DIV_CNT_W     = $clog2(WORD_W);
    localparam int PERM_W        = 7;
    localparam int OUT_W         = 6;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;
    localparam int DEF_MAX_SIZE  = 64;

    localparam logic [PERM_W-1:0] PERM_SIZE_RESET = PERM_W'(64);

    // register index is paddr[ADDR_W-1]; byte lanes below it are ignored
    localparam logic REG_PERM_SIZE = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/random_permutation_generator_top.sv =====
// Top level of the random permutation generator (original Fisher-Yates shuffle).
`default_nettype none

// One input transaction carries a 31-bit random word and yields one result transaction:
// the chosen free slot, the value placed there and a flag on the last placement of a
// permutation. An item first passes the bit-serial modulo unit (31 bit steps, then the
// remainder is taken). It then scans the taken map, one slot per cycle, until it reaches
// the chosen free slot, and the result is handed to the output register, which waits
// while the output is stalled. No new word is accepted until the block is back in idle.
// The taken map is a one-bit memory of MAX_SIZE entries; after reset, after the last
// placement of a permutation and after any write of perm_size it is cleared in a pass
// over all MAX_SIZE entries during which no input is taken. perm_size of 0 acts as 1 and
// values above MAX_SIZE act as MAX_SIZE.
module random_permutation_generator_top
    import rpg_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire  [WORD_W-1:0]   i_random_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [OUT_W-1:0]    o_slot_index,
    output logic [OUT_W-1:0]    o_placed_value,
    output logic                o_last_of_run,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [ADDR_W-1:0]   paddr,
    input  wire  [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int SW = $clog2(MAX_SIZE);
    localparam int EW = (CW > PERM_W) ? CW : PERM_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_CLEAR = 5'b10000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [PERM_W-1:0] r_perm_size;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_rem;
    logic [SW-1:0]     r_addr;
    logic [SW-1:0]     r_addr_d;
    logic              r_rd_vld;
    logic              r_rd_data;
    logic [SW-1:0]     r_clr_addr;
    logic [SW-1:0]     r_res_slot;
    logic [CW-1:0]     r_res_val;
    logic              r_res_last;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_slot;
    logic [OUT_W-1:0]  r_out_val;
    logic              r_out_last;
    logic              r_taken_mem [MAX_SIZE];

    logic [EW-1:0]     size_ext;
    logic [CW-1:0]     size_eff;
    logic              cfg_wr;
    logic              in_acc;
    logic              mod_done;
    logic [CW-1:0]     mod_rem;
    logic              found;
    logic              res_last;
    logic              out_load;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    logic              mem_wdata;
    logic              clr_end;

    always_comb begin
        size_ext = EW'(r_perm_size);
        if (size_ext == '0) begin
            size_ext = EW'(1);
        end else if (size_ext > EW'(MAX_SIZE)) begin
            size_ext = EW'(MAX_SIZE);
        end
        size_eff = size_ext[CW-1:0];
    end

    assign cfg_wr   = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_PERM_SIZE);
    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign found    = (r_state == ST_SCAN) && r_rd_vld && !r_rd_data && (r_rem == '0);
    assign res_last = ((r_count + CW'(1)) == size_eff);
    assign out_load = (r_state == ST_PUSH) && (!r_out_valid || !i_out_stall);
    assign clr_end  = (r_clr_addr == SW'(MAX_SIZE - 1));

    rpg_serial_mod #(
        .MAX_SIZE (MAX_SIZE)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc),
        .i_word    (i_random_word),
        .i_divisor (size_eff - r_count),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (mod_done) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (found) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_load) n_state = r_res_last ? ST_CLEAR : ST_IDLE;
            end
            ST_CLEAR: begin
                if (clr_end) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        if (cfg_wr) n_state = ST_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_perm_size <= PERM_SIZE_RESET;
            r_count     <= '0;
            r_clr_addr  <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_SCAN) begin
                r_rd_vld <= 1'b1;
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (found) begin
                r_count <= res_last ? '0 : r_count + CW'(1);
            end
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clr_end ? '0 : r_clr_addr + SW'(1);
            end
            if (cfg_wr) begin
                r_perm_size <= pwdata[PERM_W-1:0];
                r_count     <= '0;
                r_clr_addr  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            r_rem  <= mod_rem;
            r_addr <= '0;
        end else if (r_state == ST_SCAN) begin
            r_addr   <= r_addr + SW'(1);
            r_addr_d <= r_addr;
            if (r_rd_vld && !r_rd_data && (r_rem != '0)) begin
                r_rem <= r_rem - CW'(1);
            end
        end
        if (found) begin
            r_res_slot <= r_addr_d;
            r_res_val  <= r_count;
            r_res_last <= res_last;
        end
        if (out_load) begin
            r_out_slot <= OUT_W'(r_res_slot);
            r_out_val  <= OUT_W'(r_res_val);
            r_out_last <= r_res_last;
        end
    end

    assign mem_we    = found || (r_state == ST_CLEAR);
    assign mem_waddr = found ? r_addr_d : r_clr_addr;
    assign mem_wdata = found;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_taken_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_taken_mem[r_addr];
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_slot_index   = r_out_slot;
    assign o_placed_value = r_out_val;
    assign o_last_of_run  = r_out_last;
    assign pready         = 1'b1;
    assign prdata         = (paddr[ADDR_W-1] == REG_PERM_SIZE) ? DATA_W'(r_perm_size) : '0;

endmodule

`default_nettype wire

// ===== rtl/core/rpg_serial_mod.sv =====
// Bit-serial restoring modulo of the random word by the free slot count.
`default_nettype none

module rpg_serial_mod
    import rpg_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [WORD_W-1:0]                    i_word,
    input  wire [$clog2(MAX_SIZE+1)-1:0]        i_divisor,
    output logic                                o_done,
    output logic [$clog2(MAX_SIZE+1)-1:0]       o_rem
);

    localparam int CW = $clog2(MAX_SIZE + 1);

    logic [WORD_W-1:0]    r_word;
    logic [CW-1:0]        r_div;
    logic [CW-1:0]        r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [CW:0]          shifted;
    logic [CW:0]          diff;
    logic [CW-1:0]        n_rem;

    always_comb begin
        shifted = {r_rem, r_word[WORD_W-1]};
        diff    = shifted - {1'b0, r_div};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = diff[CW-1:0];
        end else begin
            n_rem = shifted[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(WORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_word;
            r_div  <= i_divisor;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[WORD_W-2:0], 1'b0};
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== tb/rpg_placement_checker.sv =====
// Checker for the random permutation generator: predicts every placement and compares results.
`timescale 1ns / 100ps

module rpg_placement_checker
    import rpg_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_stall,
    input  wire  [WORD_W-1:0]   i_random_word,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire  [OUT_W-1:0]    i_slot_index,
    input  wire  [OUT_W-1:0]    i_placed_value,
    input  wire                 i_last_of_run,
    input  wire                 i_psel,
    input  wire                 i_penable,
    input  wire                 i_pwrite,
    input  wire                 i_pready,
    input  wire  [ADDR_W-1:0]   i_paddr,
    input  wire  [DATA_W-1:0]   i_pwdata,
    output int                  o_mismatches,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_runs_done
);

    typedef struct packed {
        logic [OUT_W-1:0] slot_index;
        logic [OUT_W-1:0] placed_value;
        logic             last_of_run;
    } t_placement;

    logic [PERM_W-1:0]   size_reg;
    logic [MAX_SIZE-1:0] taken_map;
    int unsigned         placed_so_far;
    t_placement          placements_due[$];
    int                  mismatches;
    int                  checked;
    int                  runs_done;

    function automatic int unsigned active_size();
        if (size_reg == '0) return 1;
        if (size_reg > MAX_SIZE) return MAX_SIZE;
        return 32'(size_reg);
    endfunction

    function automatic void restart_run();
        taken_map     = '0;
        placed_so_far = 0;
    endfunction

    // pick the n-th free slot, n = word mod free slots, and place the next value there
    function automatic t_placement place_next(input logic [WORD_W-1:0] word);
        int unsigned size_now;
        int unsigned skip;
        int unsigned slot;
        logic        found;
        t_placement  p;
        size_now = active_size();
        if (placed_so_far >= size_now) restart_run();
        skip  = word % (size_now - placed_so_far);
        slot  = 0;
        found = 1'b0;
        for (int k = 0; k < MAX_SIZE; k++) begin
            if (!found && k < size_now && !taken_map[k]) begin
                if (skip == 0) begin
                    slot  = k;
                    found = 1'b1;
                end else begin
                    skip--;
                end
            end
        end
        p.slot_index    = OUT_W'(slot);
        p.placed_value  = OUT_W'(placed_so_far);
        taken_map[slot] = 1'b1;
        placed_so_far++;
        p.last_of_run   = (placed_so_far == size_now);
        if (p.last_of_run) restart_run();
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_placement due;
        if (!i_rst_n) begin
            size_reg = PERM_SIZE_RESET;
            restart_run();
            placements_due.delete();
            mismatches = 0;
            checked    = 0;
            runs_done  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[ADDR_W-1] == REG_PERM_SIZE) begin
                size_reg = i_pwdata[PERM_W-1:0];
                restart_run();
            end
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (i_last_of_run === 1'b1) runs_done++;
                if (placements_due.size() == 0) begin
                    $error({"unexpected transaction: slot_index %0d placed_value %0d",
                            " last_of_run %0b"},
                           i_slot_index, i_placed_value, i_last_of_run);
                    mismatches++;
                end else begin
                    due = placements_due.pop_front();
                    if (i_slot_index !== due.slot_index) begin
                        $error("slot_index: expected %0d, got %0d", due.slot_index, i_slot_index);
                        mismatches++;
                    end
                    if (i_placed_value !== due.placed_value) begin
                        $error("placed_value: expected %0d, got %0d",
                               due.placed_value, i_placed_value);
                        mismatches++;
                    end
                    if (i_last_of_run !== due.last_of_run) begin
                        $error("last_of_run: expected %0b, got %0b",
                               due.last_of_run, i_last_of_run);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                placements_due.push_back(place_next(i_random_word));
        end
        o_mismatches <= mismatches;
        o_pending    <= placements_due.size();
        o_checked    <= checked;
        o_runs_done  <= runs_done;
    end

endmodule

// ===== tb/random_permutation_generator_top_tb.sv =====
// Testbench top for the random permutation generator: stimulus, register writes and verdict.
`timescale 1ns / 100ps

module random_permutation_generator_top_tb;
    import rpg_pkg::*;

    localparam int                HOLD_CYCLES    = 400;
    localparam int                WATCHDOG_LIMIT = 4000;
    localparam int                SETTLE_CYCLES  = DEF_MAX_SIZE + 40;
    localparam int                PHASE_ITEMS    = 110;
    localparam int                NUM_PHASES     = 12;
    localparam logic [ADDR_W-1:0] PERM_SIZE_ADDR = {REG_PERM_SIZE, {(ADDR_W-1){1'b0}}};
    localparam logic [ADDR_W-1:0] SPARE_ADDR     = {~REG_PERM_SIZE, {(ADDR_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] WORD_MAX       = '1;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              in_valid    = 1'b0;
    logic [WORD_W-1:0] random_word = '0;
    logic              out_stall   = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic              calm        = 1'b0;
    logic              hold_req    = 1'b0;

    wire               in_stall;
    wire               out_valid;
    wire  [OUT_W-1:0]  slot_index;
    wire  [OUT_W-1:0]  placed_value;
    wire               last_of_run;
    wire  [DATA_W-1:0] prdata;
    wire               pready;

    int mismatches;
    int pending;
    int checked;
    int runs_done;
    int words_sent = 0;
    int reg_writes = 0;
    int stuck      = 0;

    always #5 clk = ~clk;

    random_permutation_generator_top dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_random_word  (random_word),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_slot_index   (slot_index),
        .o_placed_value (placed_value),
        .o_last_of_run  (last_of_run),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    rpg_placement_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_random_word  (random_word),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_slot_index   (slot_index),
        .i_placed_value (placed_value),
        .i_last_of_run  (last_of_run),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_runs_done    (runs_done)
    );

    function automatic logic [WORD_W-1:0] pick_word();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 6) return WORD_W'($urandom);
        if (pick < 8) return WORD_W'($urandom_range(80));
        return WORD_MAX - WORD_W'($urandom_range(80));
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] word);
        while (!calm && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        random_word <= word;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // stop sending and wait until every placement has come back and the map clear is over
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 17);
            end
        end
    end

    initial begin
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
                    || (psel && penable))
                stuck = 0;
            else
                stuck++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [PERM_W-1:0] phase_sizes [NUM_PHASES];
        phase_sizes = '{7'd64, 7'd1, 7'd7, 7'd64, 7'd33, 7'd2, 7'd127, 7'd16, 7'd0, 7'd3,
                        7'd0, 7'd0};
        phase_sizes[NUM_PHASES-2] = PERM_W'($urandom_range(1, 64));
        phase_sizes[NUM_PHASES-1] = PERM_W'($urandom_range(1, 64));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset size of 64
        send_word('0);
        send_word(WORD_MAX);
        send_word(WORD_W'(1));
        send_word(WORD_W'(32'h4000_0000));
        send_word(WORD_W'(32'h5555_5555));
        send_word(WORD_W'(32'h2AAA_AAAA));
        // upper data bits dropped, size zero acts as one
        write_reg(PERM_SIZE_ADDR, 32'hFFFF_FF80);
        send_word('0);
        send_word(WORD_MAX);
        send_word(WORD_W'(5));
        // unmapped register, size stays one
        write_reg(SPARE_ADDR, 32'h0000_0003);
        send_word(WORD_W'(32'h1234_5678));
        send_word('0);
        // 127 and 65 saturate to the maximum
        write_reg(PERM_SIZE_ADDR, 32'hFFFF_FFFF);
        send_word(WORD_MAX);
        send_word(WORD_MAX);
        write_reg(PERM_SIZE_ADDR, 32'h0000_0041);
        send_word(WORD_W'(1));
        write_reg(PERM_SIZE_ADDR, 32'h0000_0002);
        send_word(WORD_MAX);
        send_word(WORD_MAX);
        send_word('0);
        send_word('0);
        write_reg(PERM_SIZE_ADDR, 32'h0000_0003);
        send_word(WORD_W'(2));
        send_word(WORD_W'(1));
        send_word('0);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(PERM_SIZE_ADDR, DATA_W'(phase_sizes[ph]));
            calm     <= (ph == 3);
            hold_req <= (ph == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 7 && n == PHASE_ITEMS / 2) drain();
                send_word(pick_word());
            end
        end
        drain();

        $display("Sent %0d random words, checked %0d placements, %0d permutations completed.",
                 words_sent, checked, runs_done);
        $display("Used %0d register writes (sizes zero to 127) and a %0d-cycle output hold.",
                 reg_writes, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
